// File: src/prdb_pkg.sv
// Shared types and constants for the page range dirty bitmap.
package prdb_pkg;

   localparam int WORD_BITS = 32;
   localparam int BIT_IDX_W = 5;
   localparam logic [WORD_BITS-1:0] WORD_ONES = {WORD_BITS{1'b1}};
   localparam logic [BIT_IDX_W-1:0] BIT_IDX_MAX = 5'd31;

   typedef enum logic [1:0] {
      OP_TEST     = 2'd0,
      OP_CLEAR    = 2'd1,
      OP_MARK     = 2'd2,
      OP_MARK_ALL = 2'd3
   } op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SWEEP,
      ST_PREP,
      ST_PAGES,
      ST_READ,
      ST_EXEC,
      ST_DONE
   } state_type;

   // Controls for the word unit: the operation and the bit span inside one word.
   typedef struct packed {
      op_type               op;
      logic [BIT_IDX_W-1:0] lo;
      logic [BIT_IDX_W-1:0] hi;
   } wctl_type;

endpackage

// File: src/prdb_ram.sv
// Bitmap word memory with one write port and one registered read port.
module prdb_ram #(
   parameter int DEPTH = 512,
   parameter int AW    = 9
) (
   input  logic                           clock,
   input  logic                           wr_en,
   input  logic [AW-1:0]                  wr_addr,
   input  logic [prdb_pkg::WORD_BITS-1:0] wr_data,
   input  logic [AW-1:0]                  rd_addr,
   output logic [prdb_pkg::WORD_BITS-1:0] rd_data
);

   logic [prdb_pkg::WORD_BITS-1:0] mem [DEPTH];
   logic [prdb_pkg::WORD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/prdb_word_unit.sv
// Shared word unit: builds the bit span mask and tests, clears or marks one word.
module prdb_word_unit (
   input  prdb_pkg::wctl_type              ctl,
   input  logic [prdb_pkg::WORD_BITS-1:0]  rd_data,
   output logic [prdb_pkg::WORD_BITS-1:0]  wr_data,
   output logic                            hit
);

   logic [prdb_pkg::WORD_BITS-1:0] hi_mask;
   logic [prdb_pkg::WORD_BITS-1:0] lo_mask;
   logic [prdb_pkg::WORD_BITS-1:0] mask;

   always_comb begin
      hi_mask = prdb_pkg::WORD_ONES >> (prdb_pkg::BIT_IDX_MAX - ctl.hi);
      lo_mask = prdb_pkg::WORD_ONES << ctl.lo;
      mask    = hi_mask & lo_mask;
      hit     = |(rd_data & mask);
      case (ctl.op)
         prdb_pkg::OP_CLEAR: wr_data = rd_data & ~mask;
         prdb_pkg::OP_MARK:  wr_data = rd_data | mask;
         default:            wr_data = rd_data;
      endcase
   end

endmodule

// File: src/page_range_dirty_bitmap.sv
// Top level: request sequencer, bitmap memory and word unit of the dirty page bitmap.
//
//   channel  | ports             | payload
//   ---------+-------------------+------------------------------------------------
//   request  | req_tvalid/tready | tdata: op, byte_offset, byte_count
//   response | rsp_tvalid/tready | tdata: any_dirty
//
// A test or clear passes through the prep and page states, then reads each bitmap
// word in the range in turn (a clear also rewrites it), and then posts the
// response; a test stops at the first dirty word. Mark page takes the same path
// for one word. Reset and mark all sweep the memory to ones, one word a cycle,
// and no transaction is taken meanwhile.
// A pending response holds the block in its final state until it is taken.
// PAGE_BYTES must be a power of two; the block itself does not check it.
module page_range_dirty_bitmap #(
   parameter int PAGE_TOTAL = 16384,
   parameter int PAGE_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,  // op[1:0], byte_offset[27:2], byte_count[54:28], zero
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // any_dirty[0], zeros
);

   localparam int WordCount = (PAGE_TOTAL + 31) / 32;
   localparam int WordAw    = (WordCount > 1) ? $clog2(WordCount) : 1;
   localparam int PageW     = $clog2(PAGE_TOTAL);
   localparam int PageShift = $clog2(PAGE_BYTES);
   localparam longint unsigned RegionBytes = longint'(PAGE_TOTAL) * longint'(PAGE_BYTES);
   localparam logic [32:0] RegionV = 33'(RegionBytes);
   localparam logic [WordAw-1:0] LastWord = WordAw'(WordCount - 1);

   prdb_pkg::state_type state_ff, state_in;
   prdb_pkg::op_type    op_ff, op_in;
   logic [25:0]         offset_ff, offset_in;
   logic [26:0]         count_ff, count_in;
   logic                range_ok_ff, range_ok_in;
   logic [27:0]         endm1_ff, endm1_in;
   logic [PageW-1:0]    first_ff, first_in;
   logic [PageW-1:0]    last_ff, last_in;
   logic [WordAw-1:0]   w_ff, w_in;
   logic [WordAw-1:0]   fw_ff, fw_in;
   logic [WordAw-1:0]   lw_ff, lw_in;
   logic                hit_ff, hit_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_dirty_ff, rsp_dirty_in;

   logic                           ram_we;
   logic [WordAw-1:0]              ram_waddr;
   logic [prdb_pkg::WORD_BITS-1:0] ram_wdata;
   logic [prdb_pkg::WORD_BITS-1:0] ram_rdata;
   prdb_pkg::wctl_type             wctl;
   logic [prdb_pkg::WORD_BITS-1:0] unit_wdata;
   logic                           unit_hit;

   logic [27:0] sum;
   logic [27:0] end_c;
   logic        in_region;
   logic [25:0] offset_pages;
   logic [27:0] endm1_pages;
   logic [PageW-1:0] first_page;
   logic [PageW-1:0] last_page;
   logic [PageW-1:0] first_word_wide;
   logic [PageW-1:0] last_word_wide;

   prdb_ram #(
      .DEPTH(WordCount),
      .AW   (WordAw)
   ) u_ram (
      .clock  (clock),
      .wr_en  (ram_we),
      .wr_addr(ram_waddr),
      .wr_data(ram_wdata),
      .rd_addr(w_ff),
      .rd_data(ram_rdata)
   );

   prdb_word_unit u_word (
      .ctl    (wctl),
      .rd_data(ram_rdata),
      .wr_data(unit_wdata),
      .hit    (unit_hit)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= prdb_pkg::ST_SWEEP;
         op_ff        <= prdb_pkg::OP_TEST;
         w_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         w_ff         <= w_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      offset_ff    <= offset_in;
      count_ff     <= count_in;
      range_ok_ff  <= range_ok_in;
      endm1_ff     <= endm1_in;
      first_ff     <= first_in;
      last_ff      <= last_in;
      fw_ff        <= fw_in;
      lw_ff        <= lw_in;
      hit_ff       <= hit_in;
      rsp_dirty_ff <= rsp_dirty_in;
   end

   // Range arithmetic; each result is registered before the next step uses it.
   always_comb begin
      sum             = {2'b00, offset_ff} + {1'b0, count_ff};
      in_region       = {7'b0, offset_ff} < RegionV;
      end_c           = ({5'b0, sum} > RegionV) ? RegionV[27:0] : sum;
      offset_pages    = offset_ff >> PageShift;
      endm1_pages     = endm1_ff >> PageShift;
      first_page      = offset_pages[PageW-1:0];
      last_page       = (op_ff == prdb_pkg::OP_MARK) ? first_page : endm1_pages[PageW-1:0];
      first_word_wide = first_page >> prdb_pkg::BIT_IDX_W;
      last_word_wide  = last_page >> prdb_pkg::BIT_IDX_W;
   end

   always_comb begin
      wctl.op = op_ff;
      wctl.lo = (w_ff == fw_ff) ? first_ff[prdb_pkg::BIT_IDX_W-1:0] : '0;
      wctl.hi = (w_ff == lw_ff) ? last_ff[prdb_pkg::BIT_IDX_W-1:0] : prdb_pkg::BIT_IDX_MAX;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      offset_in    = offset_ff;
      count_in     = count_ff;
      range_ok_in  = range_ok_ff;
      endm1_in     = endm1_ff;
      first_in     = first_ff;
      last_in      = last_ff;
      w_in         = w_ff;
      fw_in        = fw_ff;
      lw_in        = lw_ff;
      hit_in       = hit_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      rsp_dirty_in = rsp_dirty_ff;
      req_tready   = 1'b0;
      ram_we       = 1'b0;
      ram_waddr    = w_ff;
      ram_wdata    = unit_wdata;

      case (state_ff)
         prdb_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               op_in     = prdb_pkg::op_type'(req_tdata[1:0]);
               offset_in = req_tdata[27:2];
               count_in  = req_tdata[54:28];
               hit_in    = 1'b0;
               w_in      = '0;
               if (prdb_pkg::op_type'(req_tdata[1:0]) == prdb_pkg::OP_MARK_ALL) begin
                  state_in = prdb_pkg::ST_SWEEP;
               end else begin
                  state_in = prdb_pkg::ST_PREP;
               end
            end
         end
         prdb_pkg::ST_SWEEP: begin
            ram_we    = 1'b1;
            ram_wdata = prdb_pkg::WORD_ONES;
            if (w_ff == LastWord) begin
               w_in     = '0;
               // The sweep after reset has no response to send.
               state_in = (op_ff == prdb_pkg::OP_MARK_ALL) ? prdb_pkg::ST_DONE
                                                          : prdb_pkg::ST_IDLE;
            end else begin
               w_in = w_ff + 1'b1;
            end
         end
         prdb_pkg::ST_PREP: begin
            range_ok_in = in_region && ((count_ff != '0) || (op_ff == prdb_pkg::OP_MARK));
            endm1_in    = end_c - 1'b1;
            state_in    = prdb_pkg::ST_PAGES;
         end
         prdb_pkg::ST_PAGES: begin
            first_in = first_page;
            last_in  = last_page;
            fw_in    = first_word_wide[WordAw-1:0];
            lw_in    = last_word_wide[WordAw-1:0];
            w_in     = first_word_wide[WordAw-1:0];
            state_in = range_ok_ff ? prdb_pkg::ST_READ : prdb_pkg::ST_DONE;
         end
         prdb_pkg::ST_READ: begin
            state_in = prdb_pkg::ST_EXEC;
         end
         prdb_pkg::ST_EXEC: begin
            if (op_ff == prdb_pkg::OP_TEST) begin
               if (unit_hit) begin
                  hit_in = 1'b1;
               end
            end else begin
               ram_we = 1'b1;
            end
            if ((op_ff == prdb_pkg::OP_TEST && unit_hit) || (w_ff == lw_ff)) begin
               state_in = prdb_pkg::ST_DONE;
            end else begin
               w_in     = w_ff + 1'b1;
               state_in = prdb_pkg::ST_READ;
            end
         end
         prdb_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_dirty_in = hit_ff;
               w_in         = '0;
               state_in     = prdb_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = prdb_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_dirty_ff};

endmodule
